[hw/rtl/ipacl_pkg.sv]
`timescale 1ns / 1ps

package ipacl_pkg;

    localparam int DEF_ENTRIES  = 16;
    localparam int NUM_DEFAULTS = 6;

    localparam logic [1:0] KIND_CHECK  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] ACT_ALLOW = 2'd0;
    localparam logic [1:0] ACT_DENY  = 2'd1;
    localparam logic [1:0] ACT_AUTH  = 2'd2;
    localparam logic [1:0] ACT_BAD   = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_TOO_LONG = 2'd2;

    localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

    typedef struct packed {
        logic        is_v6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  prefix;
        logic [1:0]  action;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic init_wr;
        logic load;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_done;
        logic scan_done;
        logic out_free;
    } dp_status_t;

    function automatic rule_t default_rule(input logic [2:0] idx);
        rule_t r;
        r = '{is_v6: 1'b0, addr_high: 64'h0, addr_low: 64'h0, prefix: 8'd0,
              action: ACT_ALLOW};
        case (idx)
            3'd0:
            begin
                r.addr_low = 64'h7F00_0000;
                r.prefix   = 8'd8;
            end
            3'd1:
            begin
                r.is_v6    = 1'b1;
                r.addr_low = 64'h1;
                r.prefix   = 8'd128;
            end
            3'd2:
            begin
                r.addr_low = 64'h0A00_0000;
                r.prefix   = 8'd8;
            end
            3'd3:
            begin
                r.addr_low = 64'hAC10_0000;
                r.prefix   = 8'd12;
            end
            3'd4:
            begin
                r.addr_low = 64'hC0A8_0000;
                r.prefix   = 8'd16;
            end
            3'd5:
            begin
                r.is_v6     = 1'b1;
                r.addr_high = 64'hFC00_0000_0000_0000;
                r.prefix    = 8'd7;
            end
            default:
            begin
                r.prefix = 8'd0;
            end
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/ip_prefix_acl_first_match.sv]
`timescale 1ns / 1ps
// A check or remove walks the held rules in order; a check stops at the first rule that
// matches, a remove walks them all and compacts the table; add and clear need no walk.
// Throughput: one item at a time, as the walk reads one rule per cycle; the next item is
// accepted once the last result has gone to the output register, which waits on the sink.
// Reset: asynchronous, active low; afterwards the six default rules are loaded, input stalled.
module ip_prefix_acl_first_match #(
    parameter int ENTRIES = ipacl_pkg::DEF_ENTRIES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // is_v6, address_high, address_low, prefix_len, rule_action_in, zero pad
    input  logic [143:0] s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // decision, matched, status, zero pad
    output logic [7:0]   m_axis_tdata
);

    import ipacl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;
    logic [1:0] decision;
    logic       matched;
    logic [1:0] status;

    ipacl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ipacl_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_kind      (s_axis_tuser),
        .in_is_v6     (s_axis_tdata[0]),
        .in_addr_high (s_axis_tdata[64:1]),
        .in_addr_low  (s_axis_tdata[128:65]),
        .in_prefix    (s_axis_tdata[136:129]),
        .in_action    (s_axis_tdata[138:137]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_decision (decision),
        .out_matched  (matched),
        .out_status   (status)
    );

    assign m_axis_tdata = {3'b000, status, matched, decision};

endmodule

[hw/rtl/ipacl_ram.sv]
`timescale 1ns / 1ps

module ipacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/ipacl_ctrl.sv]
`timescale 1ns / 1ps

module ipacl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ipacl_pkg::dp_status_t stat,
    output ipacl_pkg::ctrl_cmd_t  cmd
);

    import ipacl_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.init_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

[hw/rtl/ipacl_dp.sv]
`timescale 1ns / 1ps

module ipacl_dp #(
    parameter int ENTRIES = ipacl_pkg::DEF_ENTRIES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ipacl_pkg::ctrl_cmd_t  cmd,
    output ipacl_pkg::dp_status_t stat,
    input  logic [1:0]            in_kind,
    input  logic                  in_is_v6,
    input  logic [63:0]           in_addr_high,
    input  logic [63:0]           in_addr_low,
    input  logic [7:0]            in_prefix,
    input  logic [1:0]            in_action,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_decision,
    output logic                  out_matched,
    output logic [1:0]            out_status
);

    import ipacl_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [1:0]  kind_reg;
    rule_t       item_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] wr_idx_reg, wr_idx_next;
    logic        pend_reg, pend_next;
    logic [2:0]  init_idx_reg;
    logic [1:0]  res_decision_reg, res_decision_next;
    logic        res_matched_reg, res_matched_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        out_valid_reg;
    logic [1:0]  out_decision_reg;
    logic        out_matched_reg;
    logic [1:0]  out_status_reg;

    logic          ram_wr_en;
    logic [IW-1:0] ram_wr_addr;
    rule_t         ram_wr_data;
    logic [IW-1:0] ram_rd_addr;
    logic [RULE_W-1:0] ram_rd_raw;
    rule_t         ent;

    logic [127:0] mask128;
    logic [31:0]  mask32;
    logic         hit;
    logic         same_rule;
    logic         walking;
    logic         more;
    rule_t        norm_item;

    ipacl_ram #(.WIDTH(RULE_W), .DEPTH(ENTRIES)) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    assign ent = rule_t'(ram_rd_raw);

    always_comb
    begin
        norm_item.is_v6     = in_is_v6;
        norm_item.addr_high = in_is_v6 ? in_addr_high : 64'h0;
        norm_item.addr_low  = in_is_v6 ? in_addr_low : {32'h0, in_addr_low[31:0]};
        norm_item.prefix    = in_prefix;
        norm_item.action    = (in_action == ACT_BAD) ? ACT_DENY : in_action;
    end

    always_comb
    begin
        mask128 = ~128'h0 << (9'd128 - {1'b0, ent.prefix});
        mask32  = ~32'h0 << (9'd32 - {1'b0, ent.prefix});
        if (ent.prefix == 8'd0)
        begin
            mask128 = '0;
            mask32  = '0;
        end
        if (ent.is_v6 != item_reg.is_v6)
        begin
            hit = 1'b0;
        end
        else if (item_reg.is_v6)
        begin
            hit = (({item_reg.addr_high, item_reg.addr_low} ^
                    {ent.addr_high, ent.addr_low}) & mask128) == 128'h0;
        end
        else
        begin
            hit = ((item_reg.addr_low[31:0] ^ ent.addr_low[31:0]) & mask32) == 32'h0;
        end
        same_rule = (ent.is_v6 == item_reg.is_v6) && (ent.addr_high == item_reg.addr_high) &&
                    (ent.addr_low == item_reg.addr_low) && (ent.prefix == item_reg.prefix);
    end

    assign walking = (kind_reg == KIND_CHECK) || (kind_reg == KIND_REMOVE);
    assign more    = rd_idx_reg < count_reg;

    always_comb
    begin
        count_next        = count_reg;
        rd_idx_next       = rd_idx_reg;
        wr_idx_next       = wr_idx_reg;
        pend_next         = 1'b0;
        res_decision_next = res_decision_reg;
        res_matched_next  = res_matched_reg;
        res_status_next   = res_status_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = wr_idx_reg[IW-1:0];
        ram_wr_data       = item_reg;
        ram_rd_addr       = rd_idx_reg[IW-1:0];
        stat.scan_done    = 1'b0;
        stat.init_done    = (init_idx_reg == 3'(NUM_DEFAULTS - 1));
        stat.out_free     = !out_valid_reg || out_ready;

        if (cmd.init_wr)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = IW'(init_idx_reg);
            ram_wr_data = default_rule(init_idx_reg);
            count_next  = CW'(NUM_DEFAULTS);
        end

        if (cmd.load)
        begin
            rd_idx_next       = '0;
            wr_idx_next       = '0;
            res_decision_next = ACT_ALLOW;
            res_matched_next  = 1'b0;
            res_status_next   = STAT_OK;
        end

        if (cmd.scan)
        begin
            case (kind_reg)
                KIND_ADD:
                begin
                    stat.scan_done = 1'b1;
                    if (item_reg.prefix >
                        (item_reg.is_v6 ? V6_MAX_PREFIX : V4_MAX_PREFIX))
                    begin
                        res_status_next = STAT_TOO_LONG;
                    end
                    else if (count_reg == CW'(ENTRIES))
                    begin
                        res_status_next = STAT_FULL;
                    end
                    else
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_reg[IW-1:0];
                        count_next  = count_reg + 1'b1;
                    end
                end
                KIND_CLEAR:
                begin
                    stat.scan_done = 1'b1;
                    count_next     = '0;
                end
                default:
                begin
                    if (more)
                    begin
                        pend_next   = 1'b1;
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    if (pend_reg && kind_reg == KIND_CHECK && hit)
                    begin
                        res_decision_next = ent.action;
                        res_matched_next  = 1'b1;
                        stat.scan_done    = 1'b1;
                    end
                    if (pend_reg && kind_reg == KIND_REMOVE && !same_rule)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = wr_idx_reg[IW-1:0];
                        ram_wr_data = ent;
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end
                    if (!pend_reg && !more)
                    begin
                        stat.scan_done = 1'b1;
                        if (kind_reg == KIND_REMOVE)
                        begin
                            count_next = wr_idx_reg;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            rd_idx_reg       <= '0;
            wr_idx_reg       <= '0;
            pend_reg         <= 1'b0;
            init_idx_reg     <= '0;
            res_decision_reg <= ACT_ALLOW;
            res_matched_reg  <= 1'b0;
            res_status_reg   <= STAT_OK;
            out_valid_reg    <= 1'b0;
            kind_reg         <= KIND_CHECK;
        end
        else
        begin
            count_reg        <= count_next;
            rd_idx_reg       <= rd_idx_next;
            wr_idx_reg       <= wr_idx_next;
            pend_reg         <= cmd.scan && pend_next && !stat.scan_done;
            res_decision_reg <= res_decision_next;
            res_matched_reg  <= res_matched_next;
            res_status_reg   <= res_status_next;
            if (cmd.init_wr && !stat.init_done)
            begin
                init_idx_reg <= init_idx_reg + 3'd1;
            end
            if (cmd.load)
            begin
                kind_reg <= in_kind;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= norm_item;
        end
        if (cmd.finish)
        begin
            out_decision_reg <= res_decision_reg;
            out_matched_reg  <= res_matched_reg;
            out_status_reg   <= res_status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_decision = out_decision_reg;
    assign out_matched  = out_matched_reg;
    assign out_status   = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("rule count exceeds table size");

    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan && kind_reg == KIND_REMOVE |-> wr_idx_reg <= rd_idx_reg)
        else $error("compaction write overtook the read pointer");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result shown without a finished item");

endmodule

[tb/acl_checker.sv]
`timescale 1ns / 1ps

module acl_checker #(
    parameter int ENTRIES = ipacl_pkg::DEF_ENTRIES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [7:0]   m_axis_tdata,
    output int           failures,
    output int           pending
);

    import ipacl_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic       matched;
        logic [1:0] decision;
    } verdict_t;

    logic        valid_q[ENTRIES];
    rule_t       rules_q[ENTRIES];
    verdict_t    verdicts[$];

    function automatic logic rule_covers(rule_t r, logic v6, logic [63:0] hi, logic [63:0] lo);
        logic [127:0] mask;
        int           p;
        p = r.prefix;
        if (!v6)
        begin
            if (p > 32)
                p = 32;
            mask = (p == 0) ? 128'h0 : ({32'hFFFF_FFFF, 96'h0} >> 96) << (32 - p);
            mask = {96'h0, mask[31:0]};
        end
        else
        begin
            if (p > 128)
                p = 128;
            mask = (p == 0) ? 128'h0 : ~(128'h0) << (128 - p);
        end
        return ((({hi, lo} ^ {r.addr_high, r.addr_low}) & mask) == 128'h0);
    endfunction

    task automatic load_defaults();
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_q[i] = 1'b0;
            rules_q[i] = '0;
        end
        rules_q[0] = '{1'b0, 64'h0, 64'h7F00_0000, 8'd8, ACT_ALLOW};
        rules_q[1] = '{1'b1, 64'h0, 64'h1, 8'd128, ACT_ALLOW};
        rules_q[2] = '{1'b0, 64'h0, 64'h0A00_0000, 8'd8, ACT_ALLOW};
        rules_q[3] = '{1'b0, 64'h0, 64'hAC10_0000, 8'd12, ACT_ALLOW};
        rules_q[4] = '{1'b0, 64'h0, 64'hC0A8_0000, 8'd16, ACT_ALLOW};
        rules_q[5] = '{1'b1, 64'hFC00_0000_0000_0000, 64'h0, 8'd7, ACT_ALLOW};
        for (int i = 0; i < 6; i++)
            valid_q[i] = 1'b1;
    endtask

    function automatic verdict_t apply_item(logic [1:0] kind, logic [143:0] d);
        verdict_t    v;
        logic        v6;
        logic [63:0] hi, lo;
        logic [7:0]  plen;
        logic [1:0]  act;
        int          j;
        v    = '0;
        v6   = d[0];
        hi   = v6 ? d[64:1] : 64'h0;
        lo   = v6 ? d[128:65] : {32'h0, d[96:65]};
        plen = d[136:129];
        act  = d[138:137];
        case (kind)
            KIND_CHECK:
                for (int i = 0; i < ENTRIES; i++)
                    if (valid_q[i] && rules_q[i].is_v6 == v6 && rule_covers(rules_q[i], v6, hi, lo))
                    begin
                        v.decision = rules_q[i].action;
                        v.matched  = 1'b1;
                        break;
                    end
            KIND_ADD:
                if (plen > (v6 ? V6_MAX_PREFIX : V4_MAX_PREFIX))
                    v.status = STAT_TOO_LONG;
                else
                begin
                    v.status = STAT_FULL;
                    for (int i = 0; i < ENTRIES; i++)
                        if (!valid_q[i])
                        begin
                            valid_q[i] = 1'b1;
                            rules_q[i] = '{v6, hi, lo, plen, (act == ACT_BAD) ? ACT_DENY : act};
                            v.status = STAT_OK;
                            break;
                        end
                end
            KIND_REMOVE:
            begin
                j = 0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!valid_q[i])
                        continue;
                    if (rules_q[i].is_v6 == v6 && rules_q[i].addr_high == hi
                        && rules_q[i].addr_low == lo && rules_q[i].prefix == plen)
                        continue;
                    valid_q[j] = 1'b1;
                    rules_q[j] = rules_q[i];
                    j++;
                end
                while (j < ENTRIES)
                begin
                    valid_q[j] = 1'b0;
                    rules_q[j] = '0;
                    j++;
                end
            end
            default:
                for (int i = 0; i < ENTRIES; i++)
                begin
                    valid_q[i] = 1'b0;
                    rules_q[i] = '0;
                end
        endcase
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t got;
        if (!rst_n)
        begin
            load_defaults();
            verdicts.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                verdicts.insert(verdicts.size(), apply_item(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[4:0];
                if (verdicts.size() == 0)
                begin
                    $display("%t: unexpected result %h", $time, got);
                    failures <= failures + 1;
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (got !== want)
                    begin
                        $display("%t: expected decision %0d matched %0d status %0d, got %0d %0d %0d",
                                 $time, want.decision, want.matched, want.status,
                                 got.decision, got.matched, got.status);
                        failures <= failures + 1;
                    end
                end
            end
            pending <= verdicts.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ipacl_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    int           failures;
    int           pending;
    bit           sending_done;
    bit           hold_sink;

    ip_prefix_acl_first_match uut (.*);

    acl_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_item(logic [1:0] kind, logic v6, logic [63:0] hi, logic [63:0] lo,
                             logic [7:0] plen, logic [1:0] act);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'b0, act, plen, lo, hi, v6};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic idle_input();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Mostly addresses near held rules so that checks and removes hit.
    task automatic random_item();
        logic [1:0]  kind;
        logic        v6;
        logic [63:0] hi, lo;
        logic [7:0]  plen;
        int          r;
        r    = $urandom_range(0, 99);
        kind = (r < 45) ? KIND_CHECK : (r < 80) ? KIND_ADD : (r < 97) ? KIND_REMOVE : KIND_CLEAR;
        v6   = 1'($urandom_range(0, 1));
        hi   = {$urandom, $urandom};
        lo   = {$urandom, $urandom};
        if ($urandom_range(0, 2) != 0)
        begin
            hi = hi & 64'hFF00_0000_0000_000F;
            lo = lo & 64'h0000_000F_FF00_000F;
        end
        r = $urandom_range(0, 9);
        plen = (r == 0) ? 8'($urandom) : v6 ? 8'($urandom_range(0, 128))
                                             : 8'($urandom_range(0, 32));
        send_item(kind, v6, hi, lo, plen, 2'($urandom));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_CHECK;
        sending_done  = 1'b0;
        hold_sink     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(KIND_CHECK, 1'b0, 64'h0, 64'h7F00_0001, 8'd0, ACT_ALLOW);
        send_item(KIND_CHECK, 1'b1, 64'h0, 64'h1, 8'd0, ACT_ALLOW);
        send_item(KIND_CHECK, 1'b1, 64'hFD00_0000_0000_0000, 64'h0, 8'd0, ACT_ALLOW);
        send_item(KIND_CHECK, 1'b0, '1, '1, '1, ACT_BAD);
        send_item(KIND_ADD, 1'b0, 64'h0, 64'h0102_0304, 8'd33, ACT_DENY);
        send_item(KIND_ADD, 1'b1, '1, '1, 8'd129, ACT_DENY);
        send_item(KIND_ADD, 1'b0, '1, '1, 8'd32, ACT_BAD);
        send_item(KIND_ADD, 1'b1, '1, '1, 8'd128, ACT_AUTH);
        send_item(KIND_ADD, 1'b0, 64'h0, 64'h0, 8'd0, ACT_DENY);
        send_item(KIND_CHECK, 1'b0, 64'h0, 64'hFFFF_FFFF, 8'd0, ACT_ALLOW);
        send_item(KIND_CHECK, 1'b0, 64'h0, 64'h0505_0505, 8'd0, ACT_ALLOW);
        send_item(KIND_CHECK, 1'b1, '1, '1, 8'd0, ACT_ALLOW);
        send_item(KIND_REMOVE, 1'b0, 64'h0, 64'hFFFF_FFFF, 8'd32, ACT_ALLOW);
        send_item(KIND_REMOVE, 1'b0, 64'h0, 64'h1234, 8'd5, ACT_ALLOW);
        send_item(KIND_CHECK, 1'b0, 64'h0, 64'hFFFF_FFFF, 8'd0, ACT_ALLOW);
        for (int i = 0; i < 9; i++)
            send_item(KIND_ADD, 1'b1, 64'h0, 64'(i), 8'd128, ACT_AUTH);
        send_item(KIND_CLEAR, 1'b0, 64'h0, 64'h0, 8'd0, ACT_ALLOW);
        send_item(KIND_CHECK, 1'b0, 64'h0, 64'h0A00_0001, 8'd0, ACT_ALLOW);

        for (int i = 0; i < 1125; i++)
        begin
            if (i == 300)
            begin
                hold_sink = 1'b1;
                for (int k = 0; k < 6; k++)
                    random_item();
                hold_sink = 1'b0;
            end
            if (i == 600)
            begin
                idle_input();
                while (pending != 0)
                    @(negedge clk);
            end
            random_item();
        end
        idle_input();
        sending_done = 1'b1;
    end

    initial
    begin
        int stall;
        bit held;
        m_axis_tready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink && !held)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (150) @(negedge clk);
            end
            if (!hold_sink)
                held = 1'b0;
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
                @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        wait (sending_done);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
